[rtl/core/sbl_pkg.sv]
// Shared types and constants for the sorted bin lists block.
package sbl_pkg;

  localparam int BINS_DEF  = 4;
  localparam int SLOTS_DEF = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_REM_RD,
    ST_REM_CMP,
    ST_RD_MEM,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         bin;
    logic signed [31:0] code;
    logic [3:0]         slot;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         removed_count;
    logic [4:0]         bin_length;
    logic signed [31:0] read_code;
  } out_t;

endpackage

[rtl/core/sorted_bin_lists_top.sv]
// Sorted bin lists: per-bin ascending code lists in one memory, driven by a small sequencer.
// A clear or a refused insert goes straight to the result and a read after one memory read; an insert
// moves each stored code greater than the new one up a place, and a remove scans every bin, not only
// the one named, with one memory read and one compare per entry visited.
// One item at a time: busy stays high until the item's result has been prepared.
// Reset clears the bin counts and the sequencer; memory contents are not cleared.
// The result is shown for one cycle with out_valid; the receiver cannot stall.
module sorted_bin_lists_top #(
  parameter int BINS  = sbl_pkg::BINS_DEF,
  parameter int SLOTS = sbl_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sbl_pkg::in_t  in_data,
  output logic          out_valid,
  output sbl_pkg::out_t out_data
);

  localparam int SW    = $clog2(SLOTS);
  localparam int BW    = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int BW1   = $clog2(BINS + 1);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int TW    = $clog2(BINS * SLOTS + 1);
  localparam int DEPTH = BINS * (2 ** SW);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sbl_pkg::state_t state_r, state_nxt;

  logic [1:0]         op_r, op_nxt;
  logic [1:0]         bin_r, bin_nxt;
  logic signed [31:0] code_r, code_nxt;
  logic [3:0]         slot_r, slot_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      wr_r, wr_nxt;
  logic [BW1-1:0]     rb_r, rb_nxt;
  logic [TW-1:0]      total_r, total_nxt;
  logic [CW-1:0]      counts_r [BINS];
  logic [CW-1:0]      counts_nxt [BINS];
  sbl_pkg::out_t      out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] mem_wdata;

  logic          accept;
  logic          in_bin_ok;
  logic          bin_ok;
  logic [BW-1:0] in_bidx;
  logic [BW-1:0] bidx;
  logic [BW-1:0] rbidx;
  logic          rem_done;
  logic          ins_zero;
  logic          ins_shift;
  logic          rem_more;
  logic [CW-1:0] len_raw;
  logic [CW-1:0] idx_dec;

  assign busy      = (state_r != sbl_pkg::ST_IDLE);
  assign accept    = start && (state_r == sbl_pkg::ST_IDLE);
  assign in_bin_ok = (int'(in_data.bin) < BINS);
  assign bin_ok    = (int'(bin_r) < BINS);
  assign in_bidx   = BW'(in_data.bin);
  assign bidx      = BW'(bin_r);
  assign rbidx     = rb_r[BW-1:0];
  assign rem_done  = (rb_r == BW1'(BINS));
  assign ins_zero  = (idx_r == '0);
  assign ins_shift = (rdata_r > code_r);
  assign rem_more  = !rem_done && (idx_r < counts_r[rbidx]);
  assign idx_dec   = idx_r - CW'(1);
  assign len_raw   = bin_ok ? counts_r[bidx] : '0;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbl_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_data.op)
            sbl_pkg::OP_INSERT: begin
              if (in_bin_ok && (int'(counts_r[in_bidx]) < SLOTS)) begin
                state_nxt = sbl_pkg::ST_INS_RD;
              end else begin
                state_nxt = sbl_pkg::ST_FIN;
              end
            end
            sbl_pkg::OP_REMOVE: state_nxt = sbl_pkg::ST_REM_RD;
            sbl_pkg::OP_CLEAR:  state_nxt = sbl_pkg::ST_FIN;
            sbl_pkg::OP_READ: begin
              if (in_bin_ok && (int'(in_data.slot) < int'(counts_r[in_bidx])) &&
                  (int'(in_data.slot) < SLOTS)) begin
                state_nxt = sbl_pkg::ST_RD_MEM;
              end else begin
                state_nxt = sbl_pkg::ST_FIN;
              end
            end
            default: state_nxt = sbl_pkg::ST_FIN;
          endcase
        end
      end
      sbl_pkg::ST_INS_RD:  state_nxt = ins_zero ? sbl_pkg::ST_FIN : sbl_pkg::ST_INS_CMP;
      sbl_pkg::ST_INS_CMP: state_nxt = ins_shift ? sbl_pkg::ST_INS_RD : sbl_pkg::ST_FIN;
      sbl_pkg::ST_REM_RD: begin
        if (rem_done) begin
          state_nxt = sbl_pkg::ST_FIN;
        end else if (rem_more) begin
          state_nxt = sbl_pkg::ST_REM_CMP;
        end
      end
      sbl_pkg::ST_REM_CMP: state_nxt = sbl_pkg::ST_REM_RD;
      sbl_pkg::ST_RD_MEM:  state_nxt = sbl_pkg::ST_FIN;
      sbl_pkg::ST_FIN:     state_nxt = sbl_pkg::ST_IDLE;
      default:             state_nxt = sbl_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    op_nxt        = op_r;
    bin_nxt       = bin_r;
    code_nxt      = code_r;
    slot_nxt      = slot_r;
    status_nxt    = status_r;
    idx_nxt       = idx_r;
    wr_nxt        = wr_r;
    rb_nxt        = rb_r;
    total_nxt     = total_r;
    counts_nxt    = counts_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = AW'({bidx, idx_r[SW-1:0]});
    mem_raddr     = AW'({bidx, idx_dec[SW-1:0]});
    mem_wdata     = code_r;

    unique case (state_r)
      sbl_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt     = in_data.op;
          bin_nxt    = in_data.bin;
          code_nxt   = in_data.code;
          slot_nxt   = in_data.slot;
          status_nxt = sbl_pkg::STATUS_OK;
          total_nxt  = '0;
          idx_nxt    = '0;
          wr_nxt     = '0;
          rb_nxt     = '0;
          unique case (in_data.op)
            sbl_pkg::OP_INSERT: begin
              if (in_bin_ok && (int'(counts_r[in_bidx]) < SLOTS)) begin
                idx_nxt = counts_r[in_bidx];
              end else begin
                status_nxt = sbl_pkg::STATUS_FULL;
              end
            end
            sbl_pkg::OP_CLEAR: begin
              if (in_bin_ok) begin
                counts_nxt[in_bidx] = '0;
              end
            end
            sbl_pkg::OP_READ: begin
              if (!(in_bin_ok && (int'(in_data.slot) < int'(counts_r[in_bidx])) &&
                    (int'(in_data.slot) < SLOTS))) begin
                status_nxt = sbl_pkg::STATUS_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      sbl_pkg::ST_INS_RD: begin
        // With no stored code left below to compare, the new code lands in place 0.
        if (ins_zero) begin
          mem_we            = 1'b1;
          counts_nxt[bidx]  = counts_r[bidx] + CW'(1);
        end
      end
      sbl_pkg::ST_INS_CMP: begin
        mem_we = 1'b1;
        if (ins_shift) begin
          mem_wdata = rdata_r;
          idx_nxt   = idx_dec;
        end else begin
          counts_nxt[bidx] = counts_r[bidx] + CW'(1);
        end
      end
      sbl_pkg::ST_REM_RD: begin
        mem_raddr = AW'({rbidx, idx_r[SW-1:0]});
        if (!rem_done && !rem_more) begin
          counts_nxt[rbidx] = wr_r;
          rb_nxt            = rb_r + BW1'(1);
          idx_nxt           = '0;
          wr_nxt            = '0;
        end
      end
      sbl_pkg::ST_REM_CMP: begin
        // Surviving codes are packed down behind the read pointer.
        idx_nxt = idx_r + CW'(1);
        if (rdata_r == code_r) begin
          total_nxt = total_r + TW'(1);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = AW'({rbidx, wr_r[SW-1:0]});
          mem_wdata = rdata_r;
          wr_nxt    = wr_r + CW'(1);
        end
      end
      sbl_pkg::ST_RD_MEM: begin
        mem_raddr = AW'({bidx, SW'(slot_r)});
      end
      sbl_pkg::ST_FIN: begin
        out_valid_nxt         = 1'b1;
        out_nxt.status        = status_r;
        out_nxt.removed_count = (int'(total_r) > 127) ? 7'd127 : 7'(total_r);
        out_nxt.bin_length    = (int'(len_raw) > 31) ? 5'd31 : 5'(len_raw);
        out_nxt.read_code     = ((op_r == sbl_pkg::OP_READ) &&
                                 (status_r == sbl_pkg::STATUS_OK)) ? rdata_r : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < BINS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      counts_r    <= counts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    bin_r    <= bin_nxt;
    code_r   <= code_nxt;
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    wr_r     <= wr_nxt;
    rb_r     <= rb_nxt;
    total_r  <= total_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == sbl_pkg::STATUS_EMPTY) |-> out_data.read_code == '0)
    else $error("refused read returned a non-zero code");

  a_full_no_removal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == sbl_pkg::STATUS_FULL) |-> out_data.removed_count == '0)
    else $error("refused insert reported removed entries");
`endif

endmodule

[tb/sv/tb_sorted_bin_lists_top.sv]
// Self-checking testbench for the sorted bin lists block.
module tb_sorted_bin_lists_top;
  import sbl_pkg::*;

  localparam int BIN_COUNT  = BINS_DEF;
  localparam int SLOT_COUNT = SLOTS_DEF;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  // Own copy of the bin contents, kept in step with every accepted item.
  logic signed [31:0] bin_store [BIN_COUNT][SLOT_COUNT];
  int                 bin_fill  [BIN_COUNT];
  logic signed [31:0] code_pool [8];

  out_t expected_results [$];
  int   errors   = 0;
  int   idle_pct = 25;

  sorted_bin_lists_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic in_t make_item(logic [1:0] op, logic [1:0] bin,
                                    logic signed [31:0] code, logic [3:0] slot);
    in_t item;
    item.op   = op;
    item.bin  = bin;
    item.code = code;
    item.slot = slot;
    return item;
  endfunction

  // Applies one operation to the bin copy and returns the result it should give.
  function automatic out_t apply_bin_op(in_t cmd);
    out_t res;
    int   b;
    int   pos;
    int   kept;
    int   gone;
    res  = '0;
    b    = int'(cmd.bin);
    gone = 0;
    case (cmd.op)
      OP_INSERT: begin
        if (bin_fill[b] >= SLOT_COUNT) begin
          res.status = STATUS_FULL;
        end else begin
          // The new code goes after any codes equal to it.
          pos = 0;
          while (pos < bin_fill[b] && !(cmd.code < bin_store[b][pos])) pos++;
          for (int i = bin_fill[b]; i > pos; i--) bin_store[b][i] = bin_store[b][i-1];
          bin_store[b][pos] = cmd.code;
          bin_fill[b]++;
        end
      end
      OP_REMOVE: begin
        for (int j = 0; j < BIN_COUNT; j++) begin
          kept = 0;
          for (int i = 0; i < bin_fill[j]; i++) begin
            if (bin_store[j][i] == cmd.code) begin
              gone++;
            end else begin
              bin_store[j][kept] = bin_store[j][i];
              kept++;
            end
          end
          bin_fill[j] = kept;
        end
      end
      OP_CLEAR: begin
        bin_fill[b] = 0;
      end
      OP_READ: begin
        if (int'(cmd.slot) < bin_fill[b]) res.read_code = bin_store[b][cmd.slot];
        else res.status = STATUS_EMPTY;
      end
      default: ;
    endcase
    res.removed_count = (gone > 127) ? 7'd127 : 7'(gone);
    res.bin_length    = (bin_fill[b] > 31) ? 5'd31 : 5'(bin_fill[b]);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: result with no item outstanding", $time);
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status) report_mismatch("status", want.status, got.status);
      if (got.removed_count !== want.removed_count)
        report_mismatch("removed_count", want.removed_count, got.removed_count);
      if (got.bin_length !== want.bin_length)
        report_mismatch("bin_length", want.bin_length, got.bin_length);
      if (got.read_code !== want.read_code)
        report_mismatch("read_code", want.read_code, got.read_code);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) check_result(out_data);
  end

  // Offers one item, after a random gap on some calls, and records its expected result
  // at the edge where it is taken.
  task automatic send_item(input in_t item);
    if ($urandom_range(0, 99) < idle_pct) begin
      start   <= 1'b0;
      in_data <= make_item(2'($urandom), 2'($urandom), $urandom, 4'($urandom));
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    expected_results.push_back(apply_bin_op(item));
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function automatic logic signed [31:0] pick_code();
    if ($urandom_range(0, 9) < 6) return code_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic in_t random_item(input int insert_weight);
    int                 r;
    int                 rest;
    logic [1:0]         b;
    logic [3:0]         slot;
    r    = $urandom_range(0, 99);
    rest = 100 - insert_weight;
    b    = 2'($urandom);
    slot = 4'($urandom);
    if (r < insert_weight) return make_item(OP_INSERT, b, pick_code(), slot);
    r = r - insert_weight;
    if (r < rest / 4) return make_item(OP_REMOVE, b, pick_code(), slot);
    if (r < rest / 3) return make_item(OP_CLEAR, b, pick_code(), slot);
    // When the bin holds codes, at least half the reads pick a slot that holds one.
    if (bin_fill[b] > 0 && $urandom_range(0, 1) == 1)
      slot = 4'($urandom_range(0, bin_fill[b] - 1));
    return make_item(OP_READ, b, pick_code(), slot);
  endfunction

  task automatic test_directed();
    send_item(make_item(OP_READ,   2'd0, 32'sd0,           4'd0));
    send_item(make_item(OP_INSERT, 2'd0, 32'sd0,           4'd0));
    send_item(make_item(OP_INSERT, 2'd0, 32'sh7FFF_FFFF,   4'd0));
    send_item(make_item(OP_INSERT, 2'd0, 32'sh8000_0000,   4'd0));
    send_item(make_item(OP_INSERT, 2'd0, -32'sd1,          4'd0));
    send_item(make_item(OP_INSERT, 2'd0, 32'sd5,           4'd0));
    send_item(make_item(OP_INSERT, 2'd0, 32'sd5,           4'd0));
    send_item(make_item(OP_READ,   2'd0, 32'sd0,           4'd0));
    send_item(make_item(OP_READ,   2'd0, 32'sd0,           4'd5));
    send_item(make_item(OP_READ,   2'd0, 32'sd0,           4'd6));
    send_item(make_item(OP_READ,   2'd0, 32'sd0,           4'd15));
    send_item(make_item(OP_REMOVE, 2'd0, 32'sd5,           4'd0));
    send_item(make_item(OP_REMOVE, 2'd0, 32'sd12345,       4'd0));
    send_item(make_item(OP_INSERT, 2'd1, -32'sd1,          4'd0));
    send_item(make_item(OP_INSERT, 2'd2, -32'sd1,          4'd0));
    send_item(make_item(OP_INSERT, 2'd3, -32'sd1,          4'd0));
    // Takes -1 out of every bin, leaving bins 1 to 3 empty.
    send_item(make_item(OP_REMOVE, 2'd1, -32'sd1,          4'd0));
    send_item(make_item(OP_READ,   2'd1, 32'sd0,           4'd0));
    send_item(make_item(OP_CLEAR,  2'd0, 32'sd0,           4'd0));
    send_item(make_item(OP_READ,   2'd0, 32'sd0,           4'd0));
    send_item(make_item(OP_CLEAR,  2'd2, 32'sd0,           4'd0));
    send_item(make_item(OP_INSERT, 2'd3, 32'sh5555_5555,   4'd0));
    send_item(make_item(OP_INSERT, 2'd3, 32'shAAAA_AAAA,   4'd0));
    send_item(make_item(OP_READ,   2'd3, 32'sd0,           4'd1));
  endtask

  // Clears and fills every bin with one code, overfills each, then removes it everywhere.
  task automatic test_full_bins();
    logic signed [31:0] code;
    code = $urandom;
    for (int b = 0; b < BIN_COUNT; b++)
      send_item(make_item(OP_CLEAR, 2'(b), 32'sd0, 4'd0));
    for (int b = 0; b < BIN_COUNT; b++) begin
      for (int k = 0; k <= SLOT_COUNT; k++)
        send_item(make_item(OP_INSERT, 2'(b), code, 4'd0));
      send_item(make_item(OP_READ, 2'(b), 32'sd0, 4'd15));
    end
    send_item(make_item(OP_REMOVE, 2'd2, code, 4'd0));
    send_item(make_item(OP_READ,   2'd0, 32'sd0, 4'd0));
  endtask

  task automatic test_random_traffic(input int n_items);
    int insert_weight;
    insert_weight = 50;
    code_pool[0] = 32'sh8000_0000;
    code_pool[1] = 32'sh7FFF_FFFF;
    code_pool[2] = 32'sd0;
    code_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) code_pool[i] = $urandom;
    for (int k = 0; k < n_items; k++) begin
      // Every 100 items, switch at random between filling and emptying phases so that full bins occur.
      if (k % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_weight = 30;
          1:       insert_weight = 50;
          default: insert_weight = 75;
        endcase
      end
      if ($urandom_range(0, 299) == 0) wait_all_results();
      send_item(random_item(insert_weight));
    end
  endtask

  task automatic test_no_idle(input int n_items);
    idle_pct = 0;
    test_random_traffic(n_items);
    idle_pct = 25;
  endtask

  initial begin
    for (int b = 0; b < BIN_COUNT; b++) bin_fill[b] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    wait_all_results();
    test_full_bins();
    test_random_traffic(1200);
    test_no_idle(400);

    wait_all_results();
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/sbl_pkg.sv
rtl/core/sorted_bin_lists_top.sv
tb/sv/tb_sorted_bin_lists_top.sv
